FILE: rtl/core/iafp_pkg.sv
`timescale 1ns / 1ps

package iafp_pkg;

   localparam int FRAME_BYTES_DEFAULT = 11;

   localparam logic [7:0] HEADER_BYTE = 8'h55;
   localparam logic [7:0] ANGLE_TYPE  = 8'h53;

   localparam int TYPE_POS   = 1;
   localparam int YAW_LO_POS = 6;
   localparam int YAW_HI_POS = 7;

   localparam logic OP_BYTE    = 1'b0;
   localparam logic OP_CAPTURE = 1'b1;

   localparam logic [1:0] STATUS_NONE     = 2'd0;
   localparam logic [1:0] STATUS_ANGLE    = 2'd1;
   localparam logic [1:0] STATUS_BAD_SUM  = 2'd2;
   localparam logic [1:0] STATUS_OTHER    = 2'd3;

   typedef struct packed {
      logic       op;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic signed [15:0] raw_yaw;
      logic signed [15:0] relative_yaw;
      logic [1:0]         frame_status;
   } rsp_type;

endpackage

FILE: rtl/core/iafp_frame_core.sv
`timescale 1ns / 1ps

module iafp_frame_core #(
   parameter int FRAME_BYTES = iafp_pkg::FRAME_BYTES_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  iafp_pkg::req_type item,
   output iafp_pkg::rsp_type result
);
   import iafp_pkg::*;

   localparam int IDX_W = $clog2(FRAME_BYTES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES - 1);
   localparam logic [IDX_W-1:0] TYPE_IDX = IDX_W'(TYPE_POS);
   localparam logic [IDX_W-1:0] YLO_IDX  = IDX_W'(YAW_LO_POS);
   localparam logic [IDX_W-1:0] YHI_IDX  = IDX_W'(YAW_HI_POS);

   logic [IDX_W-1:0] byte_index_ff, byte_index_in;
   logic [7:0]       sum_ff, sum_in;
   logic [7:0]       frame_type_ff, frame_type_in;
   logic [7:0]       yaw_low_ff, yaw_low_in;
   logic [7:0]       yaw_high_ff, yaw_high_in;
   logic [15:0]      yaw_ff, yaw_in;
   logic [15:0]      yaw_ref_ff, yaw_ref_in;
   logic [1:0]       status;

   always_comb begin
      byte_index_in = byte_index_ff;
      sum_in        = sum_ff;
      frame_type_in = frame_type_ff;
      yaw_low_in    = yaw_low_ff;
      yaw_high_in   = yaw_high_ff;
      yaw_in        = yaw_ff;
      yaw_ref_in    = yaw_ref_ff;
      status        = STATUS_NONE;
      if (item.op == OP_CAPTURE) begin
         yaw_ref_in = yaw_ff;
      end else if (byte_index_ff == '0 && item.rx_byte != HEADER_BYTE) begin
         // waiting for header, byte dropped
      end else if (byte_index_ff < LAST_IDX) begin
         sum_in = (byte_index_ff == '0) ? item.rx_byte : sum_ff + item.rx_byte;
         if (byte_index_ff == TYPE_IDX) frame_type_in = item.rx_byte;
         if (byte_index_ff == YLO_IDX)  yaw_low_in    = item.rx_byte;
         if (byte_index_ff == YHI_IDX)  yaw_high_in   = item.rx_byte;
         byte_index_in = byte_index_ff + 1'b1;
      end else begin
         if (sum_ff != item.rx_byte) begin
            status = STATUS_BAD_SUM;
         end else if (frame_type_ff == ANGLE_TYPE) begin
            yaw_in = {yaw_high_ff, yaw_low_ff};
            status = STATUS_ANGLE;
         end else begin
            status = STATUS_OTHER;
         end
         byte_index_in = '0;
         sum_in        = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff <= '0;
         sum_ff        <= '0;
         frame_type_ff <= '0;
         yaw_low_ff    <= '0;
         yaw_high_ff   <= '0;
         yaw_ff        <= '0;
         yaw_ref_ff    <= '0;
      end else if (fire) begin
         byte_index_ff <= byte_index_in;
         sum_ff        <= sum_in;
         frame_type_ff <= frame_type_in;
         yaw_low_ff    <= yaw_low_in;
         yaw_high_ff   <= yaw_high_in;
         yaw_ff        <= yaw_in;
         yaw_ref_ff    <= yaw_ref_in;
      end
   end

   assign result.raw_yaw      = $signed(yaw_in);
   assign result.relative_yaw = $signed(yaw_in - yaw_ref_in);
   assign result.frame_status = status;

`ifndef NO_ASSERTIONS
   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      byte_index_ff <= LAST_IDX)
      else $error("byte index beyond checksum position");

   a_frame_end_restarts: assert property (@(posedge clock) disable iff (reset)
      fire && status != STATUS_NONE |=> byte_index_ff == '0 && sum_ff == '0)
      else $error("parser did not return to frame start");

   a_capture_keeps_frame: assert property (@(posedge clock) disable iff (reset)
      fire && item.op == OP_CAPTURE |=> $stable(byte_index_ff) && $stable(yaw_ff))
      else $error("capture disturbed frame state");

   a_yaw_only_on_angle: assert property (@(posedge clock) disable iff (reset)
      fire && status != STATUS_ANGLE |=> $stable(yaw_ff))
      else $error("yaw changed without angle frame");
`endif

endmodule

FILE: rtl/core/imu_angle_frame_parser.sv
`timescale 1ns / 1ps

// Parses the serial byte stream of an inertial sensor into checksummed frames
// and reports raw and reference-relative yaw for every transfer. One input
// transfer can be taken every cycle; each gives exactly one result, held
// first in the input register, then passed through the parser into the
// result register. The input is stalled only while the input register holds a
// transfer and the result register is full and stalled, so a stalled result
// holds the pipeline without losing or repeating any transfer.
module imu_angle_frame_parser #(
   parameter int FRAME_BYTES = iafp_pkg::FRAME_BYTES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  iafp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output iafp_pkg::rsp_type rsp_data
);
   import iafp_pkg::*;

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;
   rsp_type core_result;
   logic    out_free;
   logic    fire;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   assign in_valid_in  = (req_valid && !req_stall) || (in_valid_ff && !fire);
   assign out_valid_in = fire || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) in_data_ff <= req_data;
      if (fire) out_data_ff <= core_result;
   end

   iafp_frame_core #(
      .FRAME_BYTES(FRAME_BYTES)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .item  (in_data_ff),
      .result(core_result)
   );

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

`ifndef NO_ASSERTIONS
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && out_valid_ff && rsp_stall)
      else $error("input stalled with room in pipeline");

   a_held_item_kept: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !fire |=> in_valid_ff && $stable(in_data_ff))
      else $error("held input transfer lost");

   a_fire_fills_output: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid)
      else $error("processed transfer not presented");
`endif

endmodule

FILE: test/imu_frame_checker.sv
`timescale 1ns / 1ps

module imu_frame_checker #(
   parameter int FRAME_BYTES = iafp_pkg::FRAME_BYTES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  iafp_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  iafp_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                pending_count
);
   import iafp_pkg::*;

   rsp_type    yaw_reports[$];
   logic [3:0] frame_pos;
   logic [7:0] running_sum;
   logic [7:0] frame_kind;
   logic [7:0] yaw_lo;
   logic [7:0] yaw_hi;
   logic [15:0] yaw_word;
   logic [15:0] yaw_zero;

   function automatic rsp_type parse_transfer(req_type item);
      rsp_type    report;
      logic [1:0] status;
      status = STATUS_NONE;
      if (item.op == OP_CAPTURE) begin
         yaw_zero = yaw_word;
      end else if (!(frame_pos == 0 && item.rx_byte != HEADER_BYTE)) begin
         if (frame_pos < FRAME_BYTES - 1) begin
            running_sum = (frame_pos == 0) ? item.rx_byte : running_sum + item.rx_byte;
            if (frame_pos == TYPE_POS) frame_kind = item.rx_byte;
            if (frame_pos == YAW_LO_POS) yaw_lo = item.rx_byte;
            if (frame_pos == YAW_HI_POS) yaw_hi = item.rx_byte;
            frame_pos = frame_pos + 4'd1;
         end else begin
            if (running_sum != item.rx_byte) begin
               status = STATUS_BAD_SUM;
            end else if (frame_kind == ANGLE_TYPE) begin
               yaw_word = {yaw_hi, yaw_lo};
               status = STATUS_ANGLE;
            end else begin
               status = STATUS_OTHER;
            end
            frame_pos = '0;
            running_sum = '0;
         end
      end
      report.raw_yaw = yaw_word;
      report.relative_yaw = yaw_word - yaw_zero;
      report.frame_status = status;
      return report;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         yaw_reports.delete();
         frame_pos = '0;
         running_sum = '0;
         frame_kind = '0;
         yaw_lo = '0;
         yaw_hi = '0;
         yaw_word = '0;
         yaw_zero = '0;
         fail_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (yaw_reports.size() == 0) begin
               $display("%0t: unexpected result transfer: expected none, got %h", $time,
                        rsp_data);
               fail_count++;
            end else begin
               want = yaw_reports.pop_front();
               if (rsp_data.raw_yaw !== want.raw_yaw) begin
                  $display("%0t: raw_yaw expected %0d, got %0d", $time, want.raw_yaw,
                           rsp_data.raw_yaw);
                  fail_count++;
               end
               if (rsp_data.relative_yaw !== want.relative_yaw) begin
                  $display("%0t: relative_yaw expected %0d, got %0d", $time,
                           want.relative_yaw, rsp_data.relative_yaw);
                  fail_count++;
               end
               if (rsp_data.frame_status !== want.frame_status) begin
                  $display("%0t: frame_status expected %0d, got %0d", $time,
                           want.frame_status, rsp_data.frame_status);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) yaw_reports.push_back(parse_transfer(req_data));
      end
      pending_count = yaw_reports.size();
   end

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb;
   import iafp_pkg::*;

   localparam int LAST_POS = FRAME_BYTES_DEFAULT - 1;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   int fail_count;
   int pending_count;
   int items_sent = 0;
   bit quiet_tail = 1'b0;
   bit hold_req = 1'b0;
   bit hold_done = 1'b0;
   bit drained = 1'b0;

   always #5 clock = ~clock;

   imu_angle_frame_parser i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   imu_frame_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      #5_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // result side back-pressure
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (quiet_tail) begin
            rsp_stall <= 1'b0;
         end else if (hold_req && !hold_done) begin
            rsp_stall <= 1'b1;
            repeat (300) @(negedge clock);
            hold_done = 1'b1;
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 16) - 1) @(negedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 40) - 1) @(negedge clock);
         end
      end
   end

   task automatic send_transfer(logic op, logic [7:0] value);
      req_type item;
      item.op = op;
      item.rx_byte = value;
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      if (items_sent == 400) hold_req = 1'b1;
      quiet_tail = items_sent >= 1450;
      @(negedge clock);
      if (!quiet_tail && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
   endtask

   task automatic send_frame(logic [7:0] kind, logic [15:0] yaw, bit bad_sum, int capture_at);
      logic [7:0] frame [FRAME_BYTES_DEFAULT];
      logic [7:0] sum;
      sum = '0;
      for (int i = 0; i < LAST_POS; i++) begin
         case (i)
            0:          frame[i] = HEADER_BYTE;
            TYPE_POS:   frame[i] = kind;
            YAW_LO_POS: frame[i] = yaw[7:0];
            YAW_HI_POS: frame[i] = yaw[15:8];
            default:    frame[i] = 8'($urandom);
         endcase
         sum = sum + frame[i];
      end
      frame[LAST_POS] = bad_sum ? sum + 8'($urandom_range(1, 255)) : sum;
      for (int i = 0; i <= LAST_POS; i++) begin
         if (i == capture_at) send_transfer(OP_CAPTURE, 8'($urandom));
         send_transfer(OP_BYTE, frame[i]);
      end
   endtask

   initial begin
      int         pick;
      logic [7:0] kind;
      logic [7:0] noise;
      logic [15:0] yaw;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_transfer(OP_CAPTURE, 8'hFF);
      send_transfer(OP_BYTE, 8'h00);
      send_transfer(OP_BYTE, 8'hFF);
      send_frame(ANGLE_TYPE, 16'h8000, 1'b0, 5);
      send_transfer(OP_CAPTURE, 8'h00);
      send_frame(ANGLE_TYPE, 16'h7FFF, 1'b1, -1);

      while (items_sent < 1650) begin
         if (!drained && items_sent >= 800) begin
            drained = 1'b1;
            req_valid <= 1'b0;
            wait (pending_count == 0);
            @(negedge clock);
         end
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            kind = ($urandom_range(0, 3) != 0) ? ANGLE_TYPE : 8'($urandom);
            case ($urandom_range(0, 7))
               0:       yaw = 16'h8000;
               1:       yaw = 16'h7FFF;
               2:       yaw = 16'h0000;
               3:       yaw = 16'hFFFF;
               default: yaw = 16'($urandom);
            endcase
            send_frame(kind, yaw, $urandom_range(0, 6) == 0,
                       ($urandom_range(0, 4) == 0) ? $urandom_range(0, LAST_POS) : -1);
         end else if (pick < 80) begin
            repeat ($urandom_range(1, 4)) begin
               noise = 8'($urandom);
               if (noise == HEADER_BYTE) noise = noise ^ 8'h01;
               send_transfer(OP_BYTE, noise);
            end
         end else if (pick < 90) begin
            send_transfer(OP_CAPTURE, 8'($urandom));
         end else begin
            send_transfer(OP_BYTE, HEADER_BYTE);
            repeat (LAST_POS) send_transfer(OP_BYTE, 8'($urandom));
         end
      end

      req_valid <= 1'b0;
      wait (pending_count == 0);
      repeat (10) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
